FILE: rtl/mec_pkg.sv
// mec_pkg: shared types, constants and helpers of the mandelbrot escape counter
// used by mec_front, mec_queue, mec_back and mandelbrot_escape_counter
package mec_pkg;

  // fixed-point field widths
  localparam int unsigned Q_W      = 32;  // signed Q4.28
  localparam int unsigned PIX_W    = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned PROD_W   = 64;  // signed Q8.56
  localparam int unsigned WIDE_W   = 44;  // sums before saturation
  localparam int unsigned CFG_IDX_W = 3;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // register reset values
  localparam logic signed [Q_W-1:0]   LEFT_EDGE_RST = -32'sd671088640;
  localparam logic signed [Q_W-1:0]   TOP_EDGE_RST  = -32'sd322122547;
  localparam logic signed [Q_W-1:0]   X_STEP_RST    = 32'sd1491308;
  localparam logic signed [Q_W-1:0]   Y_STEP_RST    = 32'sd1590728;
  localparam logic [COUNT_W-1:0]      MAX_ITER_RST  = 11'd2000;

  // escape bound: 4.0 in Q8.56
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;
  // rounding offsets for the shifts by 28 and by 27
  localparam logic signed [PROD_W-1:0] ROUND_28 = 64'sh0000_0000_0800_0000;
  localparam logic signed [PROD_W-1:0] ROUND_27 = 64'sh0000_0000_0400_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_EDGE = 3'd0,
    CFG_TOP_EDGE  = 3'd1,
    CFG_X_STEP    = 3'd2,
    CFG_Y_STEP    = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_reg_e;

  // point c handed from front to back
  typedef struct packed {
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
  } point_t;

  // push side of the queue
  typedef struct packed {
    logic   valid;
    point_t point;
  } q_push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // clamp a widened sum to the Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q428(input logic signed [WIDE_W-1:0] v);
    logic all_sign;
    all_sign = (v[WIDE_W-1:Q_W-1] == '0) || (v[WIDE_W-1:Q_W-1] == '1);
    if (all_sign) begin
      sat_q428 = v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_q428 = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q428 = {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/mec_front.sv
// mec_front: takes a pixel, forms the point c = (left + col*x_step, top + row*y_step)
// depends on mec_pkg; pushes into mec_queue
module mec_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mec_pkg::PIX_W-1:0]     pixel_col,
  input  logic [mec_pkg::PIX_W-1:0]     pixel_row,
  input  logic signed [mec_pkg::Q_W-1:0] left_edge,
  input  logic signed [mec_pkg::Q_W-1:0] top_edge,
  input  logic signed [mec_pkg::Q_W-1:0] x_step,
  input  logic signed [mec_pkg::Q_W-1:0] y_step,
  input  mec_pkg::q_status_t            q_stat,
  output mec_pkg::q_push_t              q_push
);
  import mec_pkg::*;

  localparam int unsigned MUL_W = PIX_W + 1 + Q_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } f_state_t;

  f_state_t                 f_state;
  logic [PIX_W-1:0]         col_r;
  logic [PIX_W-1:0]         row_r;
  logic signed [MUL_W-1:0]  prod_x;
  logic signed [MUL_W-1:0]  prod_y;
  logic signed [WIDE_W-1:0] sum_x;
  logic signed [WIDE_W-1:0] sum_y;

  // sequencer: latch pixel, multiply, push when the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      f_state <= F_IDLE;
    end else begin
      unique case (f_state)
        F_IDLE: begin
          if (start) begin
            col_r   <= pixel_col;
            row_r   <= pixel_row;
            f_state <= F_MUL;
          end
        end
        F_MUL: begin
          prod_x  <= $signed({1'b0, col_r}) * x_step;
          prod_y  <= $signed({1'b0, row_r}) * y_step;
          f_state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            f_state <= F_IDLE;
          end
        end
        default: f_state <= F_IDLE;
      endcase
    end
  end

  // offset by the frame origin and clamp
  always_comb begin
    sum_x = {prod_x[MUL_W-1], prod_x} + {{(WIDE_W-Q_W){left_edge[Q_W-1]}}, left_edge};
    sum_y = {prod_y[MUL_W-1], prod_y} + {{(WIDE_W-Q_W){top_edge[Q_W-1]}}, top_edge};
    q_push.valid    = (f_state == F_PUSH) && !q_stat.full;
    q_push.point.cx = sat_q428(sum_x);
    q_push.point.cy = sat_q428(sum_y);
  end

  assign busy = (f_state != F_IDLE);

endmodule

FILE: rtl/mec_queue.sv
// mec_queue: short fifo of points between the front and the back
// depends on mec_pkg
module mec_queue #(
  parameter int unsigned DEPTH = mec_pkg::QUEUE_DEPTH_DEFAULT  // 2 to 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mec_pkg::q_push_t     q_push,
  input  logic                 pop,
  output mec_pkg::q_status_t   q_stat,
  output mec_pkg::point_t      head
);
  import mec_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  point_t            entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push.valid) begin
        entries[wr_ptr] <= q_push.point;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({q_push.valid, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // status and head word
  assign q_stat.full  = (fill == FULL_FILL);
  assign q_stat.empty = (fill == '0);
  assign head         = entries[rd_ptr];

endmodule

FILE: rtl/mec_back.sv
// mec_back: escape-time iteration z = z*z + c for one point at a time
// depends on mec_pkg; pops points from mec_queue
module mec_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mec_pkg::q_status_t            q_stat,
  input  mec_pkg::point_t               head,
  output logic                          pop,
  input  logic [mec_pkg::COUNT_W-1:0]   max_iterations,
  output logic                          done,
  output logic [mec_pkg::COUNT_W-1:0]   iteration_count,
  output logic                          inside_set
);
  import mec_pkg::*;

  localparam int unsigned SQ_RND_W = PROD_W - 28;  // rounded square
  localparam int unsigned XY_RND_W = PROD_W - 27;  // rounded doubled cross term

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_UPD
  } b_state_t;

  b_state_t                   b_state;
  logic signed [Q_W-1:0]      cx;
  logic signed [Q_W-1:0]      cy;
  logic signed [Q_W-1:0]      zx;
  logic signed [Q_W-1:0]      zy;
  logic [COUNT_W-1:0]         count;
  logic signed [PROD_W-1:0]   xx;
  logic signed [PROD_W-1:0]   yy;
  logic signed [PROD_W-1:0]   xy;

  logic [PROD_W-1:0]          mag_sq;
  logic                       escaped;
  logic signed [PROD_W-1:0]   xx_ofs;
  logic signed [PROD_W-1:0]   yy_ofs;
  logic signed [PROD_W-1:0]   xy_ofs;
  logic signed [SQ_RND_W-1:0] xx_rnd;
  logic signed [SQ_RND_W-1:0] yy_rnd;
  logic signed [XY_RND_W-1:0] xy_rnd;
  logic signed [WIDE_W-1:0]   nx_sum;
  logic signed [WIDE_W-1:0]   ny_sum;
  logic [COUNT_W-1:0]         count_next;

  // escape test and rounded update terms
  always_comb begin
    mag_sq  = xx + yy;
    escaped = (mag_sq >= ESCAPE_LIMIT);
    xx_ofs  = xx + ROUND_28;
    yy_ofs  = yy + ROUND_28;
    xy_ofs  = xy + ROUND_27;
    xx_rnd  = xx_ofs[PROD_W-1:28];
    yy_rnd  = yy_ofs[PROD_W-1:28];
    xy_rnd  = xy_ofs[PROD_W-1:27];
    nx_sum  = {{(WIDE_W-SQ_RND_W){xx_rnd[SQ_RND_W-1]}}, xx_rnd}
            - {{(WIDE_W-SQ_RND_W){yy_rnd[SQ_RND_W-1]}}, yy_rnd}
            + {{(WIDE_W-Q_W){cx[Q_W-1]}}, cx};
    ny_sum  = {{(WIDE_W-XY_RND_W){xy_rnd[XY_RND_W-1]}}, xy_rnd}
            + {{(WIDE_W-Q_W){cy[Q_W-1]}}, cy};
    count_next = count + 1'b1;
  end

  assign pop = (b_state == B_IDLE) && !q_stat.empty;

  // iteration sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_state <= B_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (b_state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            cx    <= head.cx;
            cy    <= head.cy;
            zx    <= '0;
            zy    <= '0;
            count <= '0;
            if (max_iterations == '0) begin
              // zero limit: nothing to iterate
              done            <= 1'b1;
              iteration_count <= '0;
              inside_set      <= 1'b1;
            end else begin
              b_state <= B_MUL;
            end
          end
        end
        B_MUL: begin
          xx      <= zx * zx;
          yy      <= zy * zy;
          xy      <= zx * zy;
          b_state <= B_UPD;
        end
        B_UPD: begin
          if (escaped) begin
            done            <= 1'b1;
            iteration_count <= count;
            inside_set      <= (count == max_iterations);
            b_state         <= B_IDLE;
          end else begin
            zx    <= sat_q428(nx_sum);
            zy    <= sat_q428(ny_sum);
            count <= count_next;
            if (count_next == max_iterations) begin
              done            <= 1'b1;
              iteration_count <= count_next;
              inside_set      <= 1'b1;
              b_state         <= B_IDLE;
            end else begin
              b_state <= B_MUL;
            end
          end
        end
        default: b_state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/mandelbrot_escape_counter.sv
// mandelbrot_escape_counter: the front turns an accepted pixel into a point, a queue
// (2 words by default) holds it, and the back iterates it until it escapes or reaches
// the limit; a zero limit gives a result without iterating. each back step is a multiply,
// then round and update; the back takes a new point only when idle, as does the front a
// new pixel. the front waits to push while the queue is full; results never stall.
// synchronous reset clears the sequencers and queue and reloads the register defaults.
module mandelbrot_escape_counter #(
  parameter int unsigned QUEUE_DEPTH = mec_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mec_pkg::PIX_W-1:0]      pixel_col,
  input  logic [mec_pkg::PIX_W-1:0]      pixel_row,
  output logic                           done,
  output logic [mec_pkg::COUNT_W-1:0]    iteration_count,
  output logic                           inside_set,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mec_pkg::Q_W-1:0]        cfg_data
);
  import mec_pkg::*;

  logic signed [Q_W-1:0] left_edge;
  logic signed [Q_W-1:0] top_edge;
  logic signed [Q_W-1:0] x_step;
  logic signed [Q_W-1:0] y_step;
  logic [COUNT_W-1:0]    max_iterations;

  q_push_t   q_push;
  q_status_t q_stat;
  point_t    head;
  logic      pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge      <= LEFT_EDGE_RST;
      top_edge       <= TOP_EDGE_RST;
      x_step         <= X_STEP_RST;
      y_step         <= Y_STEP_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_LEFT_EDGE: left_edge      <= cfg_data;
        CFG_TOP_EDGE:  top_edge       <= cfg_data;
        CFG_X_STEP:    x_step         <= cfg_data;
        CFG_Y_STEP:    y_step         <= cfg_data;
        CFG_MAX_ITER:  max_iterations <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // point generation
  mec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .left_edge (left_edge),
    .top_edge  (top_edge),
    .x_step    (x_step),
    .y_step    (y_step),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  // point queue
  mec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  // escape iteration
  mec_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .max_iterations  (max_iterations),
    .done            (done),
    .iteration_count (iteration_count),
    .inside_set      (inside_set)
  );

  // checks
  a_inside_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (inside_set == (iteration_count == max_iterations)))
    else $error("inside_set disagrees with the count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (iteration_count <= max_iterations))
    else $error("iteration count above the limit");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> !q_stat.full)
    else $error("push into a full queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front not busy after accepting a pixel");

endmodule
